[rtl/crrm_pkg.sv]
package crrm_pkg;

  // Field widths
  localparam int LEN_W      = 17;
  localparam int OFF_W      = 16;
  localparam int TOT_W      = 32;
  localparam int MODE_W     = 3;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 120;
  localparam int OUT_USER_W = 2;

  // Operation codes carried on in_tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_RESERVE   = 3'd0,
    MODE_LOOKAHEAD = 3'd1,
    MODE_STEP_BACK = 3'd2,
    MODE_RELEASE   = 3'd3,
    MODE_COMMIT    = 3'd4,
    MODE_FETCH     = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_t;

  // One request as it travels down the remainder pipeline
  typedef struct packed {
    mode_t            mode;
    logic [LEN_W-1:0] length;
    logic [LEN_W-1:0] next_length;
    logic [LEN_W-1:0] remain_length;
  } item_t;

  // One restoring remainder step: shift in a dividend bit, subtract the size if it fits
  function automatic logic [OFF_W-1:0] mod_step(input logic [OFF_W-1:0] r,
                                                input logic             b,
                                                input logic [LEN_W-1:0] s);
    logic [LEN_W-1:0] t;
    t = {r, b};
    if (t >= s) begin
      t = t - s;
    end
    return t[OFF_W-1:0];
  endfunction

  // Clamp a written ring size to [2, lim]
  function automatic logic [LEN_W-1:0] clamp_size(input logic [LEN_W-1:0] v,
                                                  input logic [LEN_W-1:0] lim);
    logic [LEN_W-1:0] r;
    r = v;
    if (r < LEN_W'(2)) begin
      r = LEN_W'(2);
    end
    if (r > lim) begin
      r = lim;
    end
    return r;
  endfunction

endpackage

[rtl/contiguous_ring_region_manager.sv]
// Offset manager for a ring buffer that grants contiguous regions; it holds no
// data bytes. Each request passes an input register, five remainder stages
// that reduce length and remain_length modulo the ring size, and one state
// update that writes the output register. One request is taken every cycle
// unless the output stalls; the single state update sets the rate. A write
// on the cfg port sets the ring size (clamped to [2, MAX_SIZE] and at most
// 65536) and resets all offsets, the used count and the committed total.
module contiguous_ring_region_manager #(
  parameter int unsigned MAX_SIZE = 65536
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // length, next_length, remain_length, zero fill
  input  logic [crrm_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode
  input  logic [crrm_pkg::MODE_W-1:0]        in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // offset, read_length, copy_source, copy_length, used_now, committed_total, zero fill
  output logic [crrm_pkg::OUT_DATA_W-1:0]    out_tdata,
  // ok, copy_needed
  output logic [crrm_pkg::OUT_USER_W-1:0]    out_tuser,
  input  logic                               cfg_wen,
  input  logic [crrm_pkg::LEN_W-1:0]         cfg_wdata
);

  localparam int unsigned LIMIT = (MAX_SIZE < 65536) ? MAX_SIZE : 65536;
  localparam logic [crrm_pkg::LEN_W-1:0] SIZE_LIM = crrm_pkg::LEN_W'(LIMIT);
  localparam logic [crrm_pkg::OFF_W-1:0] LAST_RST = crrm_pkg::OFF_W'(LIMIT - 1);

  localparam int LW = crrm_pkg::LEN_W;
  localparam int OW = crrm_pkg::OFF_W;

  crrm_pkg::item_t in_item;
  crrm_pkg::item_t p_item;
  logic            p_valid;
  logic            p_ready;
  logic [OW-1:0]   p_lm;
  logic [OW-1:0]   p_rm;
  logic            fire;

  // Ring state
  logic [LW-1:0] s_r;
  logic [OW-1:0] e_r;
  logic [OW-1:0] wr_r, wr_nxt;
  logic [OW-1:0] rd_r, rd_nxt;
  logic [OW-1:0] wrap_r, wrap_nxt;
  logic [LW-1:0] used_r, used_nxt;
  logic [crrm_pkg::TOT_W-1:0] tot_r, tot_nxt;
  logic [LW-1:0] cfg_s;

  // Result
  logic          ok_nxt, cneed_nxt;
  logic [OW-1:0] off_nxt, csrc_nxt;
  logic [LW-1:0] rlen_nxt, clen_nxt;
  logic          out_valid_r;
  logic [crrm_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [crrm_pkg::OUT_USER_W-1:0] out_user_r;

  // Unpack request
  always_comb begin
    in_item.mode          = crrm_pkg::mode_t'(in_tuser);
    in_item.length        = in_tdata[16:0];
    in_item.next_length   = in_tdata[33:17];
    in_item.remain_length = in_tdata[50:34];
  end

  crrm_mod_pipe u_mod (
    .clk        (clk),
    .rst_n      (rst_n),
    .s          (s_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .out_valid  (p_valid),
    .out_ready  (p_ready),
    .out_item   (p_item),
    .out_len_mod(p_lm),
    .out_rem_mod(p_rm)
  );

  assign p_ready = !out_valid_r || out_tready;
  assign fire    = p_valid && p_ready;
  assign cfg_s   = crrm_pkg::clamp_size(cfg_wdata, SIZE_LIM);

  // Apply one request to the ring state
  always_comb begin
    logic [LW:0]   sum_u;
    logic [LW:0]   sum_ln;
    logic [LW+1:0] sum_uln;
    logic [OW-1:0] room_w;
    logic [LW:0]   t;
    logic [OW-1:0] a;
    logic [OW-1:0] rd0;
    logic [OW-1:0] wrap0;
    logic [LW-1:0] want;
    logic [OW-1:0] room_r;
    logic [OW-1:0] n;

    sum_u   = {1'b0, used_r} + {1'b0, p_item.length};
    sum_ln  = {1'b0, p_item.length} + {1'b0, p_item.next_length};
    sum_uln = (LW+2)'(used_r) + (LW+2)'(sum_ln);
    room_w  = e_r - wr_r;
    t       = (LW+1)'(wr_r) + (LW+1)'(p_item.length);
    a       = (t >= (LW+1)'(s_r)) ? OW'(t - (LW+1)'(s_r)) : OW'(t);
    rd0     = (rd_r == wrap_r) ? '0 : rd_r;
    wrap0   = (rd_r == wrap_r) ? e_r : wrap_r;
    want    = (used_r > p_item.length) ? p_item.length : used_r;
    room_r  = (wrap0 > rd0) ? wrap0 - rd0 : '0;
    n       = (LW'(room_r) >= want) ? OW'(want) : room_r;

    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    wrap_nxt  = wrap_r;
    used_nxt  = used_r;
    tot_nxt   = tot_r;
    ok_nxt    = 1'b0;
    off_nxt   = '0;
    rlen_nxt  = '0;
    cneed_nxt = 1'b0;
    csrc_nxt  = '0;
    clen_nxt  = '0;

    case (p_item.mode)
      crrm_pkg::MODE_RESERVE: begin
        if (sum_u <= (LW+1)'(s_r)) begin
          ok_nxt = 1'b1;
          if (LW'(room_w) >= p_item.length) begin
            off_nxt = wr_r;
            wr_nxt  = OW'(t);
          end else begin
            wrap_nxt = wr_r;
            wr_nxt   = p_lm;
          end
        end
      end
      crrm_pkg::MODE_LOOKAHEAD: begin
        if (sum_uln <= (LW+2)'(s_r)) begin
          ok_nxt = 1'b1;
          if ((LW+1)'(room_w) > sum_ln) begin
            wr_nxt = OW'(t);
          end else begin
            wrap_nxt  = wr_r;
            cneed_nxt = 1'b1;
            csrc_nxt  = (a >= p_rm) ? a - p_rm : OW'(LW'(a) + s_r - LW'(p_rm));
            clen_nxt  = p_item.remain_length;
            wr_nxt    = p_rm;
          end
          off_nxt = wr_nxt;
        end
      end
      crrm_pkg::MODE_STEP_BACK: begin
        used_nxt = (used_r > p_item.length) ? used_r - p_item.length : '0;
        wr_nxt   = (wr_r >= p_lm) ? wr_r - p_lm : OW'(LW'(wr_r) + s_r - LW'(p_lm));
        ok_nxt   = 1'b1;
        off_nxt  = wr_nxt;
      end
      crrm_pkg::MODE_RELEASE: begin
        used_nxt = (used_r > p_item.length) ? used_r - p_item.length : '0;
        ok_nxt   = 1'b1;
      end
      crrm_pkg::MODE_COMMIT: begin
        used_nxt = (sum_u > (LW+1)'(s_r)) ? s_r : LW'(sum_u);
        tot_nxt  = tot_r + crrm_pkg::TOT_W'(p_item.length);
        ok_nxt   = 1'b1;
      end
      crrm_pkg::MODE_FETCH: begin
        rd_nxt   = rd0;
        wrap_nxt = wrap0;
        if (used_r != '0) begin
          ok_nxt   = 1'b1;
          off_nxt  = rd0;
          rlen_nxt = LW'(n);
          rd_nxt   = rd0 + n;
        end
      end
      crrm_pkg::MODE_CLEAR: begin
        wr_nxt   = '0;
        rd_nxt   = '0;
        wrap_nxt = e_r;
        used_nxt = '0;
        tot_nxt  = '0;
        ok_nxt   = 1'b1;
      end
      default: begin
      end
    endcase

    out_data_nxt = {5'b0, tot_nxt, used_nxt, clen_nxt, csrc_nxt, rlen_nxt, off_nxt};
  end

  // Ring state registers; a size write resets all ring state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r    <= SIZE_LIM;
      e_r    <= LAST_RST;
      wr_r   <= '0;
      rd_r   <= '0;
      wrap_r <= LAST_RST;
      used_r <= '0;
      tot_r  <= '0;
    end else if (cfg_wen) begin
      s_r    <= cfg_s;
      e_r    <= OW'(cfg_s - LW'(1));
      wr_r   <= '0;
      rd_r   <= '0;
      wrap_r <= OW'(cfg_s - LW'(1));
      used_r <= '0;
      tot_r  <= '0;
    end else if (fire) begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      wrap_r <= wrap_nxt;
      used_r <= used_nxt;
      tot_r  <= tot_nxt;
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (p_ready) begin
      out_valid_r <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
      out_user_r <= {cneed_nxt, ok_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

[rtl/crrm_mod_pipe.sv]
// Input register followed by a pipelined remainder unit that reduces length and
// remain_length modulo the ring size, four bits per stage.
module crrm_mod_pipe (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [crrm_pkg::LEN_W-1:0]    s,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  crrm_pkg::item_t               in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output crrm_pkg::item_t               out_item,
  output logic [crrm_pkg::OFF_W-1:0]    out_len_mod,
  output logic [crrm_pkg::OFF_W-1:0]    out_rem_mod
);

  localparam int STEP = 4;
  localparam int NSTG = (crrm_pkg::LEN_W + STEP - 1) / STEP;
  localparam int PW   = NSTG * STEP;

  logic                       v_r   [0:NSTG];
  crrm_pkg::item_t            item_r[0:NSTG];
  logic [crrm_pkg::OFF_W-1:0] lr_r  [0:NSTG];
  logic [crrm_pkg::OFF_W-1:0] rr_r  [0:NSTG];
  logic [crrm_pkg::OFF_W-1:0] lr_nxt[1:NSTG];
  logic [crrm_pkg::OFF_W-1:0] rr_nxt[1:NSTG];
  logic                       take  [0:NSTG];

  // Stage can load when empty or when its content moves on
  always_comb begin
    take[NSTG] = !v_r[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      take[k] = !v_r[k] || take[k+1];
    end
  end

  assign in_ready = take[0];

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= NSTG; k++) begin
        v_r[k] <= 1'b0;
      end
    end else begin
      if (take[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k <= NSTG; k++) begin
        if (take[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Input register: partial remainders start at zero
  always_ff @(posedge clk) begin
    if (take[0] && in_valid) begin
      item_r[0] <= in_item;
      lr_r[0]   <= '0;
      rr_r[0]   <= '0;
    end
  end

  // Remainder stages, most significant dividend bits first
  for (genvar k = 1; k <= NSTG; k++) begin : g_stage
    logic [PW-1:0] lp;
    logic [PW-1:0] rp;

    always_comb begin
      lp        = PW'(item_r[k-1].length);
      rp        = PW'(item_r[k-1].remain_length);
      lr_nxt[k] = lr_r[k-1];
      rr_nxt[k] = rr_r[k-1];
      for (int i = 0; i < STEP; i++) begin
        lr_nxt[k] = crrm_pkg::mod_step(lr_nxt[k], lp[PW-1-(k-1)*STEP-i], s);
        rr_nxt[k] = crrm_pkg::mod_step(rr_nxt[k], rp[PW-1-(k-1)*STEP-i], s);
      end
    end

    always_ff @(posedge clk) begin
      if (take[k] && v_r[k-1]) begin
        item_r[k] <= item_r[k-1];
        lr_r[k]   <= lr_nxt[k];
        rr_r[k]   <= rr_nxt[k];
      end
    end
  end

  assign out_valid   = v_r[NSTG];
  assign out_item    = item_r[NSTG];
  assign out_len_mod = lr_r[NSTG];
  assign out_rem_mod = rr_r[NSTG];

endmodule

[rtl/crrm_checker.sv]
// Port-level checks on the result stream
module crrm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [crrm_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [crrm_pkg::OUT_USER_W-1:0] out_tuser
);

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A refused request carries no region, chunk or copy request
  a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> !out_tuser[1] && (out_tdata[65:0] == 66'd0))
    else $error("refused request reports a grant");

  // A copy request only comes with a grant, and the used count stays in range
  a_copy_granted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && (out_tdata[82:66] <= 17'h10000))
    else $error("copy request without grant or used count out of range");

endmodule

bind contiguous_ring_region_manager crrm_checker u_crrm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
